[rtl/core/utf8_glyph_text_rasterizer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text rasterizer
// Compile-time switchable concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_GLYPH_TEXT_RASTERIZER_DEFINES_SVH
`define UTF8_GLYPH_TEXT_RASTERIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define UGR_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UGR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define UGR_ASSERT_IMPL(label, clk, rst, prop, msg)
`define UGR_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[rtl/core/ugr_pkg.sv]
// ----------------------------------------------------------------------------
// ugr_pkg
// Shared types, constants and glyph ROM for the glyph text rasterizer.
// ----------------------------------------------------------------------------
package ugr_pkg;

   localparam logic [34:0] TOFU_BITS = 35'b11111000010001000100010000000000100;
   localparam logic [20:0] CP_NEWLINE = 21'h0A;

   typedef logic [34:0] glyph_type;

   typedef struct packed {
      logic       emit_load;
      logic       emit_row;
      logic       emit_done;
      logic       nl_step;
   } ugr_ctl_type;

   typedef struct packed {
      logic       decode_last;
      logic       is_newline;
   } ugr_stat_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      if (!b[7]) return 3'd1;
      else if (b[7:5] == 3'b110) return 3'd2;
      else if (b[7:4] == 4'b1110) return 3'd3;
      else if (b[7:3] == 5'b11110) return 3'd4;
      else return 3'd1;
   endfunction

   function automatic glyph_type cyr_glyph(input logic [4:0] i);
      case (i)
         5'd0: return 35'b01110100011000111111100011000110001;
         5'd1: return 35'b11111100001000011110100011000111110;
         5'd2: return 35'b11110100011000111110100011000111110;
         5'd3: return 35'b11111100001000010000100001000010000;
         5'd4: return 35'b01110010100101001010010101111110001;
         5'd5: return 35'b11111100001111010000100001000011111;
         5'd6: return 35'b10101101011010111111101011010110101;
         5'd7: return 35'b01110100010000100110000011000101110;
         5'd8: return 35'b10001100011001110101110011000110001;
         5'd9: return 35'b01010100011000110011101011100110001;
         5'd10: return 35'b10001100101010011000101001001010001;
         5'd11: return 35'b00111001010010100101001010100110001;
         5'd12: return 35'b10001110111010110101100011000110001;
         5'd13: return 35'b10001100011000111111100011000110001;
         5'd14: return 35'b01110100011000110001100011000101110;
         5'd15: return 35'b11111100011000110001100011000110001;
         5'd16: return 35'b11110100011000111110100001000010000;
         5'd17: return 35'b01111100001000010000100001000001111;
         5'd18: return 35'b11111001000010000100001000010000100;
         5'd19: return 35'b10001100011000101111000010001001100;
         5'd20: return 35'b00100011101010110101101010111000100;
         5'd21: return 35'b10001100010101000100010101000110001;
         5'd22: return 35'b10010100101001010010100101111100001;
         5'd23: return 35'b10001100011000101111000010000100001;
         5'd24: return 35'b10101101011010110101101011010111111;
         5'd25: return 35'b10101101011010110101101011111100001;
         5'd26: return 35'b11000010000100001110010010100101110;
         5'd27: return 35'b10001100011000111001101011010111001;
         5'd28: return 35'b10000100001000011110100011000111110;
         5'd29: return 35'b11110000010000101111000010000111110;
         5'd30: return 35'b10010101011010111101101011010110010;
         default: return 35'b01111100011000101111001010100110001;
      endcase
   endfunction

   function automatic glyph_type ascii_glyph(input logic [6:0] c);
      case (c)
         7'h41: return 35'b01110100011000111111100011000110001;
         7'h42: return 35'b11110100011000111110100011000111110;
         7'h43: return 35'b01111100001000010000100001000001111;
         7'h44: return 35'b11110100011000110001100011000111110;
         7'h45: return 35'b11111100001111010000100001000011111;
         7'h46: return 35'b11111100001111010000100001000010000;
         7'h47: return 35'b01111100001000010111100011000101111;
         7'h48: return 35'b10001100011000111111100011000110001;
         7'h49: return 35'b11111001000010000100001000010011111;
         7'h4A: return 35'b00111000100001000010100101001001100;
         7'h4B: return 35'b10001100101010011000101001001010001;
         7'h4C: return 35'b10000100001000010000100001000011111;
         7'h4D: return 35'b10001110111010110101100011000110001;
         7'h4E: return 35'b10001110011010110011100011000110001;
         7'h4F: return 35'b01110100011000110001100011000101110;
         7'h50: return 35'b11110100011000111110100001000010000;
         7'h51: return 35'b01110100011000110001101011001001101;
         7'h52: return 35'b11110100011000111110101001001010001;
         7'h53: return 35'b01111100001000001110000010000111110;
         7'h54: return 35'b11111001000010000100001000010000100;
         7'h55: return 35'b10001100011000110001100011000101110;
         7'h56: return 35'b10001100011000110001100010101000100;
         7'h57: return 35'b10001100011000110101101011101110001;
         7'h58: return 35'b10001100010101000100010101000110001;
         7'h59: return 35'b10001100010101000100001000010000100;
         7'h5A: return 35'b11111000010001000100010001000011111;
         7'h30: return 35'b01110100011001110101110011000101110;
         7'h31: return 35'b00100011000010000100001000010001110;
         7'h32: return 35'b01110100010000100010001000100011111;
         7'h33: return 35'b11110000010000101110000010000111110;
         7'h34: return 35'b00010001100101010010111110001000010;
         7'h35: return 35'b11111100001111000001000010000111110;
         7'h36: return 35'b00110010001000011110100011000101110;
         7'h37: return 35'b11111000010001000100010000100001000;
         7'h38: return 35'b01110100011000101110100011000101110;
         7'h39: return 35'b01110100011000101111000010001001100;
         7'h2D: return 35'b00000000000000011111000000000000000;
         7'h2B: return 35'b00000001000010011111001000010000000;
         7'h2C: return 35'b00000000000000000000001100011001000;
         7'h21: return 35'b00100001000010000100000000010000000;
         7'h27: return 35'b01000010000100000000000000000000000;
         7'h2E: return 35'b00000000000000000000000000110001100;
         7'h3A: return 35'b00000011000110000000011000110000000;
         7'h2F: return 35'b00001000010001000100010001000010000;
         7'h25: return 35'b11001000010001000100010001000010011;
         7'h5B: return 35'b01110010000100001000010000100001110;
         7'h5D: return 35'b01110000100001000010000100001001110;
         7'h3E: return 35'b10000010000010000010001001000010000;
         7'h3C: return 35'b00001000100010001000001000010000001;
         7'h28: return 35'b00110010001000010000100000100000110;
         7'h29: return 35'b01100000100000100001000010001001100;
         7'h7C: return 35'b00100001000010000100001000010000100;
         7'h23: return 35'b01010010101111101010111110101001010;
         7'h40: return 35'b01110100011011110101101111000001110;
         7'h3D: return 35'b00000000001111100000111110000000000;
         7'h7E: return 35'b00000000000100110110000000000000000;
         7'h20: return 35'b00000000000000000000000000000000000;
         7'h5F: return 35'b00000000000000000000000000000011111;
         7'h3F: return 35'b11110000010001000100000000000000100;
         default: return TOFU_BITS;
      endcase
   endfunction

   function automatic glyph_type lookup_glyph(input logic [20:0] cp_in);
      logic [20:0] cp;
      cp = cp_in;
      if (cp >= 21'h430 && cp <= 21'h44F) cp = cp - 21'h20;
      if (cp == 21'h451) cp = 21'h401;
      if (cp == 21'h401) return 35'b01010111111000011110100001000011111;
      if (cp >= 21'h410 && cp <= 21'h42F) return cyr_glyph(5'(cp - 21'h410));
      if (cp >= 21'h61 && cp <= 21'h7A) cp = cp - 21'h20;
      if (cp >= 21'h80) return TOFU_BITS;
      return ascii_glyph(cp[6:0]);
   endfunction

endpackage

[rtl/core/ugr_ctrl.sv]
// ----------------------------------------------------------------------------
// ugr_ctrl
// Sequencer: walks decode units of a byte buffer and steps glyph rows.
// ----------------------------------------------------------------------------
module ugr_ctrl
   import ugr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   input  logic         decode_go,
   input  ugr_stat_type stat,
   output ugr_ctl_type  ctl
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_UNIT = 4'b0010,
      ST_ROW  = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] row_ff, row_in;
   logic       vld_ff, vld_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      vld_in   = vld_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && decode_go) state_in = ST_UNIT;
         end
         ST_UNIT: begin
            if (stat.is_newline) begin
               ctl.nl_step = 1'b1;
               if (stat.decode_last) state_in = ST_IDLE;
            end else begin
               ctl.emit_load = 1'b1;
               row_in   = 3'd0;
               vld_in   = 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (rsp_ready) begin
               ctl.emit_row = 1'b1;
               if (row_ff == 3'd6) begin
                  ctl.emit_done = 1'b1;
                  vld_in = 1'b0;
                  state_in = stat.decode_last ? ST_IDLE : ST_UNIT;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

[rtl/core/ugr_dpath.sv]
// ----------------------------------------------------------------------------
// ugr_dpath
// Datapath: byte buffer, decode, pen registers and glyph row output.
// ----------------------------------------------------------------------------
module ugr_dpath
   import ugr_pkg::*;
#(
   parameter int COORD_BITS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_byte,
   input  logic               end_of_text,
   input  logic signed [15:0] origin_x,
   input  logic signed [15:0] origin_y,
   input  logic [31:0]        draw_color,
   input  logic [3:0]         scale,
   input  ugr_ctl_type        ctl,
   output logic               decode_go,
   output ugr_stat_type       stat,
   output logic signed [15:0] row_x,
   output logic signed [15:0] row_y,
   output logic [4:0]         row_pixels,
   output logic [31:0]        row_color,
   output logic               last_row
);

   localparam int CB = COORD_BITS;

   logic [CB-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in, lsx_ff, lsx_in;
   logic [CB-1:0] rowy_ff, rowy_in;
   logic [7:0]    held_ff [3];
   logic [7:0]    buf_ff [4];
   logic [2:0]    cnt_ff, cnt_in;
   logic [2:0]    pos_ff, pos_in;
   logic [2:0]    n_ff;
   logic [31:0]   color_ff, color_in;
   logic          mid_ff, mid_in;
   logic [34:0]   glyph_ff;
   logic [CB-1:0] px_ext, py_ext;

   logic [2:0] first_cnt, n_new, need;
   logic [7:0] b0, b1, b2, b3;
   logic [2:0] len, left;
   logic [20:0] cp;
   logic [2:0] scan_pos;
   logic [3:0] scan_info;
   logic       glyph_last;

   function automatic logic [3:0] unit_info(input logic [7:0] c0, c1, c2, c3,
                                            input logic [2:0] rem);
      logic [2:0]  ulen;
      logic [20:0] ucp;
      ulen = lead_length(c0);
      ucp  = {13'd0, c0};
      if (ulen == 3'd2 && rem >= 3'd2)
         ucp = {10'd0, c0[4:0], c1[5:0]};
      else if (ulen == 3'd3 && rem >= 3'd3)
         ucp = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
      else if (ulen == 3'd4 && rem >= 3'd4)
         ucp = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
      else ulen = 3'd1;
      return {ucp == CP_NEWLINE, ulen};
   endfunction

   assign px_ext = CB'(origin_x);
   assign py_ext = CB'(origin_y);
   assign first_cnt = mid_ff ? cnt_ff : 3'd0;
   assign n_new = first_cnt + 3'd1;
   assign need = lead_length(first_cnt == 3'd0 ? text_byte : held_ff[0]);
   assign decode_go = (n_new >= need) || end_of_text;

   always_comb begin
      b0 = buf_ff[pos_ff[1:0]];
      b1 = buf_ff[2'(pos_ff + 3'd1)];
      b2 = buf_ff[2'(pos_ff + 3'd2)];
      b3 = buf_ff[2'(pos_ff + 3'd3)];
      left = n_ff - pos_ff;
      len = lead_length(b0);
      cp = {13'd0, b0};
      if (len == 3'd2 && left >= 3'd2)
         cp = {10'd0, b0[4:0], b1[5:0]};
      else if (len == 3'd3 && left >= 3'd3)
         cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      else if (len == 3'd4 && left >= 3'd4)
         cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      else len = 3'd1;
      stat.is_newline  = (cp == CP_NEWLINE);
      stat.decode_last = (3'(pos_ff + len) >= n_ff);
      glyph_last = 1'b1;
      scan_info  = '0;
      scan_pos   = 3'(pos_ff + len);
      for (int k = 0; k < 3; k++) begin
         if (scan_pos < n_ff) begin
            scan_info = unit_info(buf_ff[scan_pos[1:0]], buf_ff[2'(scan_pos + 3'd1)],
                                  buf_ff[2'(scan_pos + 3'd2)], buf_ff[2'(scan_pos + 3'd3)],
                                  3'(n_ff - scan_pos));
            if (!scan_info[3]) glyph_last = 1'b0;
            scan_pos = 3'(scan_pos + scan_info[2:0]);
         end
      end
   end

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      lsx_in   = lsx_ff;
      color_in = color_ff;
      mid_in   = mid_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      rowy_in  = rowy_ff;
      if (accept) begin
         if (!mid_ff) begin
            pen_x_in = px_ext;
            lsx_in   = px_ext;
            pen_y_in = py_ext;
            color_in = draw_color;
         end
         mid_in = !end_of_text;
         cnt_in = decode_go ? 3'd0 : n_new;
         pos_in = 3'd0;
      end
      if (ctl.nl_step) begin
         pen_x_in = lsx_ff;
         pen_y_in = pen_y_ff + CB'({scale, 3'd0});
         pos_in   = pos_ff + len;
      end
      if (ctl.emit_load) rowy_in = pen_y_ff;
      if (ctl.emit_row) rowy_in = rowy_ff + CB'(scale);
      if (ctl.emit_done) begin
         pen_x_in = pen_x_ff + CB'({scale, 2'd0}) + CB'({scale, 1'd0});
         pos_in   = pos_ff + len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         lsx_ff   <= '0;
         color_ff <= '0;
         mid_ff   <= 1'b0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         lsx_ff   <= lsx_in;
         color_ff <= color_in;
         mid_ff   <= mid_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rowy_ff <= rowy_in;
      if (accept) begin
         n_ff <= n_new;
         for (int i = 0; i < 3; i++) begin
            if (3'(i) < first_cnt) buf_ff[i] <= held_ff[i];
            else if (3'(i) == first_cnt) buf_ff[i] <= text_byte;
         end
         if (first_cnt == 3'd3) buf_ff[3] <= text_byte;
         if (!decode_go && first_cnt < 3'd3) held_ff[first_cnt[1:0]] <= text_byte;
      end
      if (ctl.emit_load) glyph_ff <= lookup_glyph(cp);
      else if (ctl.emit_row) glyph_ff <= {glyph_ff[29:0], 5'd0};
   end

   assign row_x      = 16'(pen_x_ff);
   assign row_y      = 16'(rowy_ff);
   assign row_pixels = glyph_ff[34:30];
   assign row_color  = color_ff;
   assign last_row   = glyph_last;

endmodule

[rtl/core/utf8_glyph_text_rasterizer.sv]
// A byte that completes a glyph moves the sequencer from idle to its unit state, which
// loads the glyph register and raises rsp_valid with the first row; then one row a cycle
// while rsp_ready is high (7 rows a glyph). No new byte is accepted until every decode
// unit of the buffer is shown or stepped; a newline unit is stepped with no row output.
// Synchronous active-high reset clears pen, string and sequencer state.
// ----------------------------------------------------------------------------
// utf8_glyph_text_rasterizer
// UTF-8 text to 5x7 glyph row generator with scalable pen.
// ----------------------------------------------------------------------------
`include "utf8_glyph_text_rasterizer_defines.svh"
module utf8_glyph_text_rasterizer
   import ugr_pkg::*;
#(
   parameter int COORD_BITS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic [31:0]        req_draw_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_row_x,
   output logic signed [15:0] rsp_row_y,
   output logic [4:0]         rsp_row_pixels,
   output logic [31:0]        rsp_row_color,
   output logic               rsp_last_row,
   input  logic               csr_we,
   input  logic [3:0]         csr_wdata
);

   logic [3:0]   scale_ff;
   logic         decode_go, glyph_last;
   ugr_stat_type stat;
   ugr_ctl_type  ctl;
   logic [2:0]   rows_left_ff;

   always_ff @(posedge clock) begin
      if (reset) scale_ff <= 4'd1;
      else if (csr_we) scale_ff <= csr_wdata;
   end

   ugr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_ready, .rsp_valid,
      .decode_go, .stat, .ctl
   );

   ugr_dpath #(.COORD_BITS(COORD_BITS)) u_dpath (
      .clock, .reset,
      .accept(req_valid && req_ready),
      .text_byte(req_text_byte), .end_of_text(req_end_of_text),
      .origin_x(req_origin_x), .origin_y(req_origin_y), .draw_color(req_draw_color),
      .scale(scale_ff), .ctl, .decode_go, .stat,
      .row_x(rsp_row_x), .row_y(rsp_row_y), .row_pixels(rsp_row_pixels),
      .row_color(rsp_row_color), .last_row(glyph_last)
   );

   always_ff @(posedge clock) begin
      if (reset) rows_left_ff <= '0;
      else if (ctl.emit_load) rows_left_ff <= 3'd6;
      else if (ctl.emit_row && rows_left_ff != 3'd0) rows_left_ff <= rows_left_ff - 3'd1;
   end

   assign rsp_last_row = rsp_valid && (rows_left_ff == 3'd0) && glyph_last;

   `UGR_ASSERT_NEVER(a_no_accept_busy, clock, reset, (req_valid && req_ready && rsp_valid),
      "input accepted while rows pending")
   `UGR_ASSERT_IMPL(a_load_shows, clock, reset, (ctl.emit_load |=> rsp_valid),
      "glyph load without row output")
   `UGR_ASSERT_NEVER(a_nl_no_row, clock, reset, (ctl.nl_step && rsp_valid),
      "newline step while a row is shown")

endmodule
